[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TPE_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("tpe assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TPE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("tpe assertion failed");

`endif

[hw/rtl/tpe_pkg.sv]
`timescale 1ns / 1ps

package tpe_pkg;

    localparam int MAX_SIDES_N  = 63;
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);

    localparam logic [5:0]       MAX_SIDES      = 6'(MAX_SIDES_N);
    localparam logic [CNT_W-1:0] LAST_STEP      = CNT_W'(CORDIC_STEPS - 1);

    // Angles in 1/256 degree.
    localparam logic [16:0] QUARTER_TURN       = 17'd23040;
    localparam logic [16:0] HALF_TURN          = 17'd46080;
    localparam logic [16:0] THREE_QUARTER_TURN = 17'd69120;
    localparam logic [16:0] FULL_TURN          = 17'd92160;

    // Inverse CORDIC gain (1/K), 16 fraction bits.
    localparam logic signed [16:0] CORDIC_GAIN = 17'sd39797;

    localparam logic signed [26:0] POS_MAX_W = 27'sd8388607;
    localparam logic signed [26:0] POS_MIN_W = -27'sd8388608;

    typedef logic [4:0] t_atan_idx;

    // atan(2^-i) in degrees, 16 fraction bits.
    localparam logic [21:0] ATAN_Q16 [24] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // Whole degrees turned per polygon side, floor(360 / sides).
    localparam logic [8:0] SIDE_TURN_DEG [64] = '{
        9'd0,   9'd360, 9'd180, 9'd120, 9'd90,  9'd72,  9'd60,  9'd51,
        9'd45,  9'd40,  9'd36,  9'd32,  9'd30,  9'd27,  9'd25,  9'd24,
        9'd22,  9'd21,  9'd20,  9'd18,  9'd18,  9'd17,  9'd16,  9'd15,
        9'd15,  9'd14,  9'd13,  9'd13,  9'd12,  9'd12,  9'd12,  9'd11,
        9'd11,  9'd10,  9'd10,  9'd10,  9'd10,  9'd9,   9'd9,   9'd9,
        9'd9,   9'd8,   9'd8,   9'd8,   9'd8,   9'd8,   9'd7,   9'd7,
        9'd7,   9'd7,   9'd7,   9'd7,   9'd6,   9'd6,   9'd6,   9'd6,
        9'd6,   9'd6,   9'd6,   9'd6,   9'd6,   9'd5,   9'd5,   9'd5
    };

    typedef enum logic [2:0] {
        ACT_GOTO = 3'd0,
        ACT_TURN = 3'd1,
        ACT_WALK = 3'd2,
        ACT_FILL = 3'd3,
        ACT_POLY = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        KIND_POSE       = 3'd0,
        KIND_MOVETO     = 3'd1,
        KIND_LINETO     = 3'd2,
        KIND_CLOSE      = 3'd3,
        KIND_CLOSE_FILL = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_seq_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_ROUND
    } t_cordic_state;

    typedef struct packed {
        logic               start;
        logic signed [15:0] seg_len;
        logic [16:0]        heading;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [25:0] dx;
        logic signed [25:0] dy;
    } t_cordic_rsp;

    // Add a signed turn to a heading and fold back into [0, 360).
    function automatic logic [16:0] wrap_heading(input logic [16:0] h,
                                                 input logic signed [17:0] d);
        logic signed [19:0] s;
        logic signed [19:0] full;
        begin
            full = $signed({3'b000, FULL_TURN});
            s    = $signed({3'b000, h}) + {{2{d[17]}}, d};
            if (s < 20'sd0) s = s + full;
            if (s < 20'sd0) s = s + full;
            if (s >= full) s = s - full;
            if (s >= full) s = s - full;
            return s[16:0];
        end
    endfunction

    // Clamp a coordinate sum to the 24-bit range.
    function automatic logic signed [23:0] sat_pos(input logic signed [26:0] v);
        begin
            if (v > POS_MAX_W) return POS_MAX_W[23:0];
            if (v < POS_MIN_W) return POS_MIN_W[23:0];
            return v[23:0];
        end
    endfunction

endpackage

[hw/rtl/tpe_if.sv]
`timescale 1ns / 1ps

interface tpe_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [17:0] turn_angle;
    logic signed [15:0] distance;
    logic [5:0]         sides;

    modport source (output valid, action, target_x, target_y, turn_angle, distance,
                    sides, input ready);
    modport sink (input valid, action, target_x, target_y, turn_angle, distance,
                  sides, output ready);
endinterface

interface tpe_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [16:0]        heading_out;
    logic               last;

    modport source (output valid, kind, point_x, point_y, heading_out, last,
                    input ready);
    modport sink (input valid, kind, point_x, point_y, heading_out, last,
                  output ready);
endinterface

[hw/rtl/tpe_cordic.sv]
`timescale 1ns / 1ps

module tpe_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpe_pkg::t_cordic_req i_req,
    output tpe_pkg::t_cordic_rsp o_rsp
);

    tpe_pkg::t_cordic_state r_state, n_state;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [25:0] r_z, n_z;
    logic               r_neg, n_neg;
    logic [tpe_pkg::CNT_W-1:0] r_i, n_i;
    logic               r_done, n_done;
    logic signed [25:0] r_dx, n_dx;
    logic signed [25:0] r_dy, n_dy;

    logic signed [32:0] w_prod;
    logic signed [17:0] w_hs;
    logic signed [17:0] w_a;
    logic               w_fold_neg;
    logic signed [33:0] w_xs, w_ys;
    logic signed [25:0] w_atan;
    logic signed [33:0] w_xr, w_yr;
    logic signed [25:0] w_xq, w_yq;

    assign w_prod = i_req.seg_len * tpe_pkg::CORDIC_GAIN;
    assign w_hs   = $signed({1'b0, i_req.heading});

    // Fold heading into [-90, 90]; the back half-plane negates the result.
    always_comb begin
        w_fold_neg = 1'b0;
        if (i_req.heading <= tpe_pkg::QUARTER_TURN) begin
            w_a = w_hs;
        end else if (i_req.heading < tpe_pkg::THREE_QUARTER_TURN) begin
            w_a        = w_hs - $signed({1'b0, tpe_pkg::HALF_TURN});
            w_fold_neg = 1'b1;
        end else begin
            w_a = w_hs - $signed({1'b0, tpe_pkg::FULL_TURN});
        end
    end

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = $signed({4'b0000, tpe_pkg::ATAN_Q16[tpe_pkg::t_atan_idx'(r_i)]});
    assign w_xr   = r_x + 34'sd128;
    assign w_yr   = r_y + 34'sd128;
    assign w_xq   = w_xr[33:8];
    assign w_yq   = w_yr[33:8];

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_neg   = r_neg;
        n_i     = r_i;
        n_done  = 1'b0;
        n_dx    = r_dx;
        n_dy    = r_dy;
        unique case (r_state)
            tpe_pkg::C_IDLE: begin
                if (i_req.start) begin
                    n_x     = {w_prod[32], w_prod};
                    n_y     = '0;
                    n_z     = {w_a, 8'h00};
                    n_neg   = w_fold_neg;
                    n_i     = '0;
                    n_state = tpe_pkg::C_ITER;
                end
            end
            tpe_pkg::C_ITER: begin
                if (!r_z[25]) begin
                    n_x = r_x - w_ys;
                    n_y = r_y + w_xs;
                    n_z = r_z - w_atan;
                end else begin
                    n_x = r_x + w_ys;
                    n_y = r_y - w_xs;
                    n_z = r_z + w_atan;
                end
                n_i = r_i + 1'b1;
                if (r_i == tpe_pkg::LAST_STEP) begin
                    n_state = tpe_pkg::C_ROUND;
                end
            end
            tpe_pkg::C_ROUND: begin
                n_dx    = r_neg ? -w_xq : w_xq;
                n_dy    = r_neg ? -w_yq : w_yq;
                n_done  = 1'b1;
                n_state = tpe_pkg::C_IDLE;
            end
            default: begin
                n_state = tpe_pkg::C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpe_pkg::C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
        r_i   <= n_i;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.dx   = r_dx;
    assign o_rsp.dy   = r_dy;

endmodule

[hw/rtl/turtle_pose_engine_core.sv]
// Goto, turn, toggle fill and unused codes pass from acceptance through the emit state to the
// output register; a walk goes through start, load, 16 CORDIC steps, round, pose update and
// result. Throughput: one request at a time; a polygon walks its N sides one after another.
// The CORDIC unit is the one shared datapath.
// Reset (synchronous, active low) zeroes position, heading and fill and drops pending results.
`timescale 1ns / 1ps

module turtle_pose_engine_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tpe_cmd_if.sink         i_cmd,
    tpe_res_if.source       o_res
);

    // Sequencer state and the pose registers.
    tpe_pkg::t_seq_state r_state, n_state;
    logic signed [23:0]  r_pos_x, n_pos_x;
    logic signed [23:0]  r_pos_y, n_pos_y;
    logic [16:0]         r_heading, n_heading;
    logic                r_fill, n_fill;
    logic [5:0]          r_sides_left, n_sides_left;

    // Context of the request in flight.
    tpe_pkg::t_kind      r_kind, n_kind;
    logic                r_last, n_last;
    logic                r_poly, n_poly;
    logic signed [17:0]  r_step, n_step;
    logic signed [15:0]  r_dist, n_dist;
    logic                r_cstart, n_cstart;

    // Output register: a finished result waits here for the sink.
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_out_kind, n_out_kind;
    logic signed [23:0]  r_out_x, n_out_x;
    logic signed [23:0]  r_out_y, n_out_y;
    logic [16:0]         r_out_heading, n_out_heading;
    logic                r_out_last, n_out_last;

    tpe_pkg::t_cordic_req w_req;
    tpe_pkg::t_cordic_rsp w_rsp;
    logic                 w_out_free;
    logic [5:0]           w_cnt;
    tpe_pkg::t_kind       w_close_kind;
    logic signed [26:0]   w_sum_x, w_sum_y;

    // Walk unit: rotates the side length by the current heading.
    assign w_req.start   = r_cstart;
    assign w_req.seg_len = r_dist;
    assign w_req.heading = r_heading;

    tpe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_free   = !r_out_valid || o_res.ready;
    // Clamp the side count to the largest polygon supported.
    assign w_cnt        = (i_cmd.sides > tpe_pkg::MAX_SIDES) ? tpe_pkg::MAX_SIDES : i_cmd.sides;
    assign w_close_kind = r_fill ? tpe_pkg::KIND_CLOSE_FILL : tpe_pkg::KIND_CLOSE;
    assign w_sum_x      = {{3{r_pos_x[23]}}, r_pos_x} + {w_rsp.dx[25], w_rsp.dx};
    assign w_sum_y      = {{3{r_pos_y[23]}}, r_pos_y} + {w_rsp.dy[25], w_rsp.dy};

    // Take a new request only between requests.
    assign i_cmd.ready = (r_state == tpe_pkg::S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_heading     = r_heading;
        n_fill        = r_fill;
        n_sides_left  = r_sides_left;
        n_kind        = r_kind;
        n_last        = r_last;
        n_poly        = r_poly;
        n_step        = r_step;
        n_dist        = r_dist;
        n_cstart      = 1'b0;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_kind    = r_out_kind;
        n_out_x       = r_out_x;
        n_out_y       = r_out_y;
        n_out_heading = r_out_heading;
        n_out_last    = r_out_last;

        unique case (r_state)
            tpe_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_dist  = i_cmd.distance;
                    n_last  = 1'b1;
                    n_poly  = 1'b0;
                    n_kind  = tpe_pkg::KIND_POSE;
                    n_state = tpe_pkg::S_EMIT;
                    unique case (i_cmd.action)
                        tpe_pkg::ACT_GOTO: begin
                            n_pos_x = i_cmd.target_x;
                            n_pos_y = i_cmd.target_y;
                            n_kind  = tpe_pkg::KIND_MOVETO;
                        end
                        tpe_pkg::ACT_TURN: begin
                            n_heading = tpe_pkg::wrap_heading(r_heading, i_cmd.turn_angle);
                        end
                        tpe_pkg::ACT_WALK: begin
                            n_kind   = tpe_pkg::KIND_LINETO;
                            n_cstart = 1'b1;
                            n_state  = tpe_pkg::S_WALK;
                        end
                        tpe_pkg::ACT_FILL: begin
                            n_fill = !r_fill;
                        end
                        tpe_pkg::ACT_POLY: begin
                            n_step       = {1'b0, tpe_pkg::SIDE_TURN_DEG[w_cnt], 8'h00};
                            n_sides_left = w_cnt;
                            n_poly       = 1'b1;
                            if (w_cnt == 6'd0) begin
                                // No sides: close the path at once.
                                n_kind = w_close_kind;
                            end else begin
                                n_kind   = tpe_pkg::KIND_LINETO;
                                n_last   = 1'b0;
                                n_cstart = 1'b1;
                                n_state  = tpe_pkg::S_WALK;
                            end
                        end
                        default: begin
                            // Unused codes: report the pose unchanged.
                            n_kind = tpe_pkg::KIND_POSE;
                        end
                    endcase
                end
            end
            tpe_pkg::S_WALK: begin
                if (w_rsp.done) begin
                    n_pos_x = tpe_pkg::sat_pos(w_sum_x);
                    n_pos_y = tpe_pkg::sat_pos(w_sum_y);
                    if (r_poly) begin
                        // Turn after each side and count it off.
                        n_heading    = tpe_pkg::wrap_heading(r_heading, r_step);
                        n_sides_left = r_sides_left - 6'd1;
                    end
                    n_state = tpe_pkg::S_EMIT;
                end
            end
            tpe_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = r_kind;
                    n_out_x       = r_pos_x;
                    n_out_y       = r_pos_y;
                    n_out_heading = r_heading;
                    n_out_last    = r_last;
                    if (r_last) begin
                        n_state = tpe_pkg::S_IDLE;
                    end else if (r_sides_left != 6'd0) begin
                        // Next polygon side.
                        n_cstart = 1'b1;
                        n_state  = tpe_pkg::S_WALK;
                    end else begin
                        // Sides done: queue the closepath and hold here.
                        n_kind = w_close_kind;
                        n_last = 1'b1;
                    end
                end
            end
            default: begin
                n_state = tpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tpe_pkg::S_IDLE;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_fill       <= 1'b0;
            r_sides_left <= '0;
            r_cstart     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_heading    <= n_heading;
            r_fill       <= n_fill;
            r_sides_left <= n_sides_left;
            r_cstart     <= n_cstart;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and request context: no reset needed.
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_last        <= n_last;
        r_poly        <= n_poly;
        r_step        <= n_step;
        r_dist        <= n_dist;
        r_out_kind    <= n_out_kind;
        r_out_x       <= n_out_x;
        r_out_y       <= n_out_y;
        r_out_heading <= n_out_heading;
        r_out_last    <= n_out_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.point_x     = r_out_x;
    assign o_res.point_y     = r_out_y;
    assign o_res.heading_out = r_out_heading;
    assign o_res.last        = r_out_last;

endmodule

[hw/rtl/tpe_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  i_res_kind,
    input logic [23:0] i_res_x,
    input logic [23:0] i_res_y,
    input logic [16:0] i_res_heading,
    input logic        i_res_last
);

    // A stalled result holds.
    `TPE_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_kind) && $stable(i_res_x) && $stable(i_res_y) && $stable(i_res_heading) && $stable(i_res_last))

    // One request at a time: drop ready right after acceptance.
    `TPE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready)

    // Only polygon sides leave a request open.
    `TPE_ASSERT_IMPL(a_open_is_lineto, i_clk, i_rst_n, i_res_valid && !i_res_last, i_res_kind == tpe_pkg::KIND_LINETO)

    // Heading stays inside one full turn.
    `TPE_ASSERT_IMPL(a_heading_range, i_clk, i_rst_n, i_res_valid, i_res_heading < tpe_pkg::FULL_TURN)

endmodule

bind turtle_pose_engine_core tpe_checker u_tpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_kind    (o_res.kind),
    .i_res_x       (o_res.point_x),
    .i_res_y       (o_res.point_y),
    .i_res_heading (o_res.heading_out),
    .i_res_last    (o_res.last)
);

[dv/tb_turtle_pose_engine_core.sv]
`timescale 1ns / 1ps

module tb_turtle_pose_engine_core;

    // Spare action codes: the core must leave the pose alone and report it.
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // Angles in 1/256 degree.
    localparam longint DEG_QUARTER = 23040;
    localparam longint DEG_HALF    = 46080;
    localparam longint DEG_THREE_Q = 69120;
    localparam longint DEG_FULL    = 92160;

    localparam int     CORDIC_ITERS    = 16;
    localparam longint CORDIC_GAIN_Q16 = 39797;
    localparam int     POLY_SIDES_MAX  = 63;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
    localparam longint ATAN_DEG_Q16 [CORDIC_ITERS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    localparam int RANDOM_CMDS  = 220;
    localparam int SETTLE_TICKS = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        logic signed [17:0] ang;
        logic signed [15:0] seg_len;
        logic [5:0]         sides;
    } t_cmd;

    typedef struct packed {
        tpe_pkg::t_kind     kind;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [16:0]        h;
        logic               fin;
    } t_path_elem;

    typedef struct packed {
        t_cmd       cmd;
        logic       fixed;
        t_path_elem want;
    } t_dir_row;

    localparam t_path_elem FROM_MODEL = '{tpe_pkg::KIND_POSE, 24'sd0, 24'sd0, 17'd0, 1'b0};

    // Directed requests. Rows with a fixed result carry it typed in; the others
    // rely on the pose predictor below.
    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // spare code right after reset: pose is all zero
        '{'{ACT_SPARE_5, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sd0, 24'sd0, 17'd0, 1'b1}},
        // jump to the corner: x at max, y at min
        '{'{tpe_pkg::ACT_GOTO, 24'sh7FFFFF, 24'sh800000, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_MOVETO, 24'sh7FFFFF, 24'sh800000, 17'd0, 1'b1}},
        // longest forward walk from there: x saturates high
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sd32767, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_GOTO, 24'sh800000, 24'sh7FFFFF, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_MOVETO, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1}},
        // whole turns either way land back on zero
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sd92160, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1}},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, -18'sd92160, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1}},
        // field extremes beyond one turn: wrap modulo 360 degrees
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sh20000, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sh800000, 24'sh7FFFFF, 17'd53248, 1'b1}},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sh1FFFF, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sh800000, 24'sh7FFFFF, 17'd92159, 1'b1}},
        '{'{tpe_pkg::ACT_FILL, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sh800000, 24'sh7FFFFF, 17'd92159, 1'b1}},
        // most negative walk just below a full turn
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sh8000, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_GOTO, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_MOVETO, 24'sd0, 24'sd0, 17'd92159, 1'b1}},
        // empty polygon with fill armed: only the filled closepath
        '{'{tpe_pkg::ACT_POLY, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_CLOSE_FILL, 24'sd0, 24'sd0, 17'd92159, 1'b1}},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sd1, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sd0, 24'sd0, 17'd0, 1'b1}},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sd23040, 16'sd0, 6'd0}, 1'b1,
          '{tpe_pkg::KIND_POSE, 24'sd0, 24'sd0, 17'd23040, 1'b1}},
        // walks on both sides of each half-plane fold boundary
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sd1000, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sd1, 16'sd0, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sd1000, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, 18'sd46079, 16'sd0, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sd1000, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_TURN, 24'sd0, 24'sd0, -18'sd1, 16'sd0, 6'd0}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_WALK, 24'sd0, 24'sd0, 18'sd0, 16'sd500, 6'd0}, 1'b0, FROM_MODEL},
        // single side: a full 360 degree turn per side
        '{'{tpe_pkg::ACT_POLY, 24'sd0, 24'sd0, 18'sd0, 16'sd100, 6'd1}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_FILL, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b0, FROM_MODEL},
        // largest side count, then a triangle big enough to saturate
        '{'{tpe_pkg::ACT_POLY, 24'sd0, 24'sd0, 18'sd0, 16'sd7, 6'd63}, 1'b0, FROM_MODEL},
        '{'{tpe_pkg::ACT_POLY, 24'sd0, 24'sd0, 18'sd0, 16'sd32767, 6'd3}, 1'b0, FROM_MODEL},
        '{'{ACT_SPARE_7, 24'sd0, 24'sd0, 18'sd0, 16'sd0, 6'd0}, 1'b0, FROM_MODEL}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic take_ready = 1'b0;
    bit   idle_en    = 1'b1;

    tpe_cmd_if cmd_bus();
    tpe_res_if res_bus();

    assign res_bus.ready = take_ready;

    turtle_pose_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predicted pose and the path points still owed by the core.
    logic signed [23:0] pen_x       = 24'sd0;
    logic signed [23:0] pen_y       = 24'sd0;
    logic [16:0]        pen_heading = 17'd0;
    bit                 fill_armed  = 1'b0;
    t_path_elem         path_q [$];

    int errors         = 0;
    int cmds_sent      = 0;
    int points_checked = 0;
    int polys_sent     = 0;
    int walks_sent     = 0;
    int cycles         = 0;

    function automatic logic signed [23:0] clamp_coord(input longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic void rotate_heading(input longint delta);
        longint s;
        s = (longint'(pen_heading) + delta) % DEG_FULL;
        if (s < 0) s += DEG_FULL;
        pen_heading = s[16:0];
    endfunction

    // Fold the heading into [-90, 90] degrees, rotate (len*K, 0) through it
    // with a floor-shift CORDIC, round to 8 fraction bits, then flip the step
    // back if the heading came from the rear half-plane.
    function automatic void walk_pen(input logic signed [15:0] seg_len);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        bit     rear;
        rear = 1'b0;
        a    = longint'(pen_heading);
        if (a > DEG_QUARTER) begin
            if (a < DEG_THREE_Q) begin
                a    = a - DEG_HALF;
                rear = 1'b1;
            end else begin
                a = a - DEG_FULL;
            end
        end
        x = longint'(seg_len) * CORDIC_GAIN_Q16;
        y = 0;
        z = a * 256;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_DEG_Q16[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_DEG_Q16[i];
            end
            x = nx;
            y = ny;
        end
        x = (x + 128) >>> 8;
        y = (y + 128) >>> 8;
        if (rear) begin
            x = -x;
            y = -y;
        end
        pen_x = clamp_coord(longint'(pen_x) + x);
        pen_y = clamp_coord(longint'(pen_y) + y);
    endfunction

    function automatic void note_point(input tpe_pkg::t_kind k, input logic fin);
        t_path_elem p;
        p = '{k, pen_x, pen_y, pen_heading, fin};
        path_q.push_back(p);
    endfunction

    // Apply one accepted request to the predicted pose and queue its points.
    function automatic void advance_pose(input t_cmd c);
        int     sides_todo;
        longint side_turn;
        case (c.action)
            tpe_pkg::ACT_GOTO: begin
                pen_x = c.tx;
                pen_y = c.ty;
                note_point(tpe_pkg::KIND_MOVETO, 1'b1);
            end
            tpe_pkg::ACT_TURN: begin
                rotate_heading(longint'(c.ang));
                note_point(tpe_pkg::KIND_POSE, 1'b1);
            end
            tpe_pkg::ACT_WALK: begin
                walk_pen(c.seg_len);
                note_point(tpe_pkg::KIND_LINETO, 1'b1);
            end
            tpe_pkg::ACT_FILL: begin
                fill_armed = !fill_armed;
                note_point(tpe_pkg::KIND_POSE, 1'b1);
            end
            tpe_pkg::ACT_POLY: begin
                sides_todo = int'(c.sides);
                if (sides_todo > POLY_SIDES_MAX) sides_todo = POLY_SIDES_MAX;
                side_turn = (sides_todo != 0) ? longint'(360 / sides_todo) * 256 : 0;
                for (int s = 0; s < sides_todo && s < POLY_SIDES_MAX; s++) begin
                    walk_pen(c.seg_len);
                    rotate_heading(side_turn);
                    note_point(tpe_pkg::KIND_LINETO, 1'b0);
                end
                note_point(fill_armed ? tpe_pkg::KIND_CLOSE_FILL : tpe_pkg::KIND_CLOSE, 1'b1);
            end
            default: begin
                note_point(tpe_pkg::KIND_POSE, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string what,
                                        input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // Hold the request until the core takes it, then advance the prediction.
    // An idle burst may come first; valid is never dropped and raised in one step.
    task automatic issue_cmd(input t_cmd c);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.action     <= c.action;
        cmd_bus.target_x   <= c.tx;
        cmd_bus.target_y   <= c.ty;
        cmd_bus.turn_angle <= c.ang;
        cmd_bus.distance   <= c.seg_len;
        cmd_bus.sides      <= c.sides;
        @(posedge i_clk);
        while (cmd_bus.ready !== 1'b1) @(posedge i_clk);
        cmds_sent++;
        if (c.action == tpe_pkg::ACT_POLY) polys_sent++;
        if (c.action == tpe_pkg::ACT_WALK) walks_sent++;
        advance_pose(c);
    endtask

    // Result side: stall in random bursts while idling is on, and compare every
    // taken point with the oldest one owed.
    always @(posedge i_clk) begin : take_points
        int         stall_left;
        t_path_elem want;
        if (i_rst_n && res_bus.valid === 1'b1 && take_ready) begin
            if (path_q.size() == 0) begin
                $display("%0t: unexpected point kind %0d x %0d y %0d heading %0d last %0d",
                         $time, res_bus.kind, res_bus.point_x, res_bus.point_y,
                         res_bus.heading_out, res_bus.last);
                errors++;
            end else begin
                want = path_q.pop_front();
                points_checked++;
                check_field("kind", want.kind, res_bus.kind);
                check_field("point_x", want.x, res_bus.point_x);
                check_field("point_y", want.y, res_bus.point_y);
                check_field("heading_out", want.h, res_bus.heading_out);
                check_field("last", want.fin, res_bus.last);
            end
        end
        if (stall_left > 0) begin
            take_ready <= 1'b0;
            stall_left  = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            take_ready <= 1'b0;
            stall_left  = $urandom_range(0, 11);
        end else begin
            take_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no progress, %0d points still owed", $time, path_q.size());
            $display("turtle_pose_engine_core: mismatch");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        int   pick;
        cmd_bus.valid      = 1'b0;
        cmd_bus.action     = tpe_pkg::ACT_GOTO;
        cmd_bus.target_x   = 24'sd0;
        cmd_bus.target_y   = 24'sd0;
        cmd_bus.turn_angle = 18'sd0;
        cmd_bus.distance   = 16'sd0;
        cmd_bus.sides      = 6'd0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; swap in the typed result where there is one.
        for (int r = 0; r < DIR_ROWS; r++) begin
            issue_cmd(DIRECTED[r].cmd);
            if (DIRECTED[r].fixed) begin
                void'(path_q.pop_back());
                path_q.push_back(DIRECTED[r].want);
            end
        end

        // Random requests: every field random, then shaped by action. Keep gotos
        // and walks mostly short so the pen roams without pinning at the rails.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            idle_en   = !(n >= 100 && n < 130) && (n < RANDOM_CMDS - 40);
            c.tx      = 24'($urandom);
            c.ty      = 24'($urandom);
            c.ang     = 18'($urandom);
            c.seg_len = 16'($urandom);
            c.sides   = 6'($urandom);
            pick      = $urandom_range(0, 99);
            if (pick < 20) begin
                c.action = tpe_pkg::ACT_GOTO;
                if ($urandom_range(0, 7) != 0) begin
                    c.tx = 24'(int'($urandom_range(0, 200000)) - 100000);
                    c.ty = 24'(int'($urandom_range(0, 200000)) - 100000);
                end
            end else if (pick < 40) begin
                c.action = tpe_pkg::ACT_TURN;
            end else if (pick < 68) begin
                c.action = tpe_pkg::ACT_WALK;
                if ($urandom_range(0, 3) != 0)
                    c.seg_len = 16'(int'($urandom_range(0, 4000)) - 2000);
            end else if (pick < 76) begin
                c.action = tpe_pkg::ACT_FILL;
            end else if (pick < 94) begin
                c.action  = tpe_pkg::ACT_POLY;
                c.sides   = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(9, 63))
                                                         : 6'($urandom_range(0, 8));
                c.seg_len = 16'(int'($urandom_range(0, 600)) - 300);
            end else begin
                case ($urandom_range(0, 2))
                    0:       c.action = ACT_SPARE_5;
                    1:       c.action = ACT_SPARE_6;
                    default: c.action = ACT_SPARE_7;
                endcase
            end
            issue_cmd(c);
        end
        cmd_bus.valid <= 1'b0;

        // Drain, then give a stray late point time to show up.
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Sent %0d requests (%0d walks, %0d polygons) under random stalls;",
                 cmds_sent, walks_sent, polys_sent);
        $display("checked %0d path points, %0d field errors.", points_checked, errors);
        if (errors == 0) begin
            $display("turtle_pose_engine_core: match");
        end else begin
            $display("turtle_pose_engine_core: mismatch");
        end
        $finish;
    end

endmodule
